/* hdl/utf8qc_pkg.sv */
// utf8qc_pkg: types, result codes and code point range helpers for the utf-8 query classifier
// no dependencies; imported by every module of the block

package utf8qc_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CODE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00dfff;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              last_byte;
    } t_item;

    function automatic logic in_cjk_range(input logic [CP_W-1:0] cp);
        return (cp >= 21'h003400 && cp <= 21'h004dbf) ||
               (cp >= 21'h004e00 && cp <= 21'h009fff) ||
               (cp >= 21'h020000 && cp <= 21'h03134f);
    endfunction

    function automatic logic is_code_char(input logic [CP_W-1:0] cp);
        return (cp >= 21'h000061 && cp <= 21'h00007a) ||
               cp == 21'h00003a || cp == 21'h000027;
    endfunction

endpackage

/* hdl/utf8qc_in_reg.sv */
// utf8qc_in_reg: input register stage holding one incoming word
// depends on utf8qc_pkg for the item struct

module utf8qc_in_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  utf8qc_pkg::t_item      i_item,
    output logic                   o_valid,
    input  logic                   i_take,
    output utf8qc_pkg::t_item      o_item
);
    import utf8qc_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/utf8qc_core.sv */
// utf8qc_core: strict utf-8 decode state, query classification and result register
// depends on utf8qc_pkg for types, constants and range helpers

module utf8qc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  utf8qc_pkg::t_item              i_item,
    output logic                           o_take,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [utf8qc_pkg::KIND_W-1:0]  o_kind
);
    import utf8qc_pkg::*;

    logic [1:0]      r_pending, n_pending, u_pending;
    logic [CP_W-1:0] r_partial, n_partial, u_partial;
    logic [1:0]      r_class,   n_class,   u_class;
    logic            r_cjk,     n_cjk,     u_cjk;
    logic            r_code,    n_code,    u_code;
    logic            r_failed,  n_failed,  u_failed;
    logic            r_saw,     n_saw,     u_saw;
    logic            r_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;

    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   shifted;
    logic [CP_W-1:0]   minimum;
    logic [CP_W-1:0]   cp;
    logic              finish;

    assign o_take  = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign b       = i_item.data_byte;
    assign shifted = {r_partial[CP_W-7:0], b[5:0]};

    always_comb begin
        case (r_class)
            SEQ_TWO:   minimum = MIN_TWO;
            SEQ_THREE: minimum = MIN_THREE;
            default:   minimum = MIN_FOUR;
        endcase
    end

    // decode one byte
    always_comb begin
        u_pending = r_pending;
        u_partial = r_partial;
        u_class   = r_class;
        u_failed  = r_failed;
        u_saw     = r_saw;
        finish    = 1'b0;
        cp        = {{(CP_W-BYTE_W){1'b0}}, b};
        if (i_item.has_byte) begin
            u_saw = 1'b1;
            if (!r_failed) begin
                if (r_pending == 2'd0) begin
                    if (!b[7]) begin
                        finish = 1'b1;
                    end else if (b[7:5] == 3'b110) begin
                        u_pending = 2'd1;
                        u_partial = {{(CP_W-5){1'b0}}, b[4:0]};
                        u_class   = SEQ_TWO;
                    end else if (b[7:4] == 4'b1110) begin
                        u_pending = 2'd2;
                        u_partial = {{(CP_W-4){1'b0}}, b[3:0]};
                        u_class   = SEQ_THREE;
                    end else if (b[7:3] == 5'b11110) begin
                        u_pending = 2'd3;
                        u_partial = {{(CP_W-3){1'b0}}, b[2:0]};
                        u_class   = SEQ_FOUR;
                    end else begin
                        u_failed = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    u_failed = 1'b1;
                end else if (r_pending == 2'd1) begin
                    u_pending = 2'd0;
                    u_partial = '0;
                    u_class   = SEQ_NONE;
                    cp        = shifted;
                    if (shifted < minimum || shifted > CP_MAX ||
                        (shifted >= SURR_LO && shifted <= SURR_HI)) begin
                        u_failed = 1'b1;
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    u_pending = r_pending - 2'd1;
                    u_partial = shifted;
                end
            end
        end
        u_cjk  = r_cjk  && !(finish && !in_cjk_range(cp));
        u_code = r_code && !(finish && !is_code_char(cp));
    end

    // classify at end of query and clear for the next one
    always_comb begin
        if (!u_saw) begin
            n_kind = KIND_EMPTY;
        end else if (u_failed || u_pending != 2'd0) begin
            n_kind = KIND_INVALID;
        end else if (u_cjk) begin
            n_kind = KIND_TEXT;
        end else if (u_code) begin
            n_kind = KIND_CODE;
        end else begin
            n_kind = KIND_INVALID;
        end
        if (i_item.last_byte) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_class   = SEQ_NONE;
            n_cjk     = 1'b1;
            n_code    = 1'b1;
            n_failed  = 1'b0;
            n_saw     = 1'b0;
        end else begin
            n_pending = u_pending;
            n_partial = u_partial;
            n_class   = u_class;
            n_cjk     = u_cjk;
            n_code    = u_code;
            n_failed  = u_failed;
            n_saw     = u_saw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_class   <= SEQ_NONE;
            r_cjk     <= 1'b1;
            r_code    <= 1'b1;
            r_failed  <= 1'b0;
            r_saw     <= 1'b0;
        end else if (o_take) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_class   <= n_class;
            r_cjk     <= n_cjk;
            r_code    <= n_code;
            r_failed  <= n_failed;
            r_saw     <= n_saw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last_byte) begin
            r_kind <= n_kind;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last_byte) |=>
        (r_pending == 2'd0 && !r_failed && !r_saw && r_cjk && r_code))
        else $error("query state not cleared after last word");

    a_pending_has_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0) == (r_class != SEQ_NONE))
        else $error("pending count and sequence class disagree");

    a_pending_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= r_class)
        else $error("more continuation bytes pending than sequence allows");

    a_pending_saw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0 || r_failed) |-> r_saw)
        else $error("decode state set without any byte seen");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_kind)))
        else $error("stalled result lost or changed");

endmodule

/* hdl/utf8_query_classifier.sv */
// utf8_query_classifier: top level, input register stage followed by decode and result register
// depends on utf8qc_pkg, utf8qc_in_reg and utf8qc_core
//
//   channel   dir  payload                                     end mark
//   s_axis    in   tdata: data_byte[7:0]; tuser: has_byte     tlast: last_byte
//   m_axis    out  tdata: query_kind[1:0], zero padded to 8   none
//
// each word sits in the input register while the decode logic works on it,
// so the result word is registered once the last word of its query leaves the input register
// one word is accepted every cycle while the result side is not stalled
// a stalled result holds and blocks the decoder; the input register absorbs one
// further word, then s_axis_tready drops
// synchronous active-low reset returns the decoder to an empty query

module utf8_query_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic       s_axis_tuser,   // has_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // query_kind[1:0], zeros above
);
    import utf8qc_pkg::*;

    t_item             w_in_item;
    t_item             w_reg_item;
    logic              w_reg_valid;
    logic              w_take;
    logic [KIND_W-1:0] w_kind;

    assign w_in_item.data_byte = s_axis_tdata;
    assign w_in_item.has_byte  = s_axis_tuser;
    assign w_in_item.last_byte = s_axis_tlast;

    utf8qc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_reg_valid),
        .i_take  (w_take),
        .o_item  (w_reg_item)
    );

    utf8qc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_reg_valid),
        .i_item  (w_reg_item),
        .o_take  (w_take),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (w_kind)
    );

    assign m_axis_tdata = {{(8-KIND_W){1'b0}}, w_kind};

endmodule

/* test/utf8_query_classifier_checker.sv */
// utf8_query_classifier_checker: watches both stream channels of the classifier,
// predicts the query kind of every finished query and compares each result word
// depends on utf8qc_pkg for the kind and sequence codes and the code point limits

module utf8_query_classifier_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // data_byte[7:0]
    input  logic       i_s_tuser,    // has_byte
    input  logic       i_s_tlast,    // last_byte
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // query_kind[1:0], zeros above
    output int         o_errors,
    output int         o_outstanding
);
    import utf8qc_pkg::*;

    logic [1:0]        cont_left;
    logic [CP_W-1:0]   cp_accum;
    logic [1:0]        seq_len;
    logic              only_cjk;
    logic              only_code;
    logic              bad_utf8;
    logic              got_byte;
    logic [KIND_W-1:0] kinds_due [$];
    logic [KIND_W-1:0] want_kind;

    function automatic void clear_query();
        cont_left = 2'd0;
        cp_accum  = '0;
        seq_len   = SEQ_NONE;
        only_cjk  = 1'b1;
        only_code = 1'b1;
        bad_utf8  = 1'b0;
        got_byte  = 1'b0;
    endfunction

    function automatic void note_cp(input logic [CP_W-1:0] cp);
        if (!((cp >= 21'h3400 && cp <= 21'h4dbf) || (cp >= 21'h4e00 && cp <= 21'h9fff) ||
              (cp >= 21'h20000 && cp <= 21'h3134f)))
            only_cjk = 1'b0;
        if (!((cp >= 21'h61 && cp <= 21'h7a) || cp == 21'h3a || cp == 21'h27))
            only_code = 1'b0;
    endfunction

    function automatic void take_word(input logic [7:0] b, input logic has, input logic last);
        logic [CP_W-1:0]   cp_floor;
        logic [KIND_W-1:0] kind;
        if (has) begin
            got_byte = 1'b1;
            if (!bad_utf8) begin
                if (cont_left == 2'd0) begin
                    if (!b[7]) begin
                        note_cp({13'd0, b});
                    end else if (b[7:5] == 3'b110) begin
                        cont_left = 2'd1;
                        cp_accum  = {16'd0, b[4:0]};
                        seq_len   = SEQ_TWO;
                    end else if (b[7:4] == 4'b1110) begin
                        cont_left = 2'd2;
                        cp_accum  = {17'd0, b[3:0]};
                        seq_len   = SEQ_THREE;
                    end else if (b[7:3] == 5'b11110) begin
                        cont_left = 2'd3;
                        cp_accum  = {18'd0, b[2:0]};
                        seq_len   = SEQ_FOUR;
                    end else begin
                        bad_utf8 = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    bad_utf8 = 1'b1;
                end else begin
                    cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        cp_floor = (seq_len == SEQ_TWO)   ? MIN_TWO :
                                   (seq_len == SEQ_THREE) ? MIN_THREE : MIN_FOUR;
                        if (cp_accum < cp_floor || cp_accum > CP_MAX ||
                            (cp_accum >= SURR_LO && cp_accum <= SURR_HI))
                            bad_utf8 = 1'b1;
                        else
                            note_cp(cp_accum);
                        cp_accum = '0;
                        seq_len  = SEQ_NONE;
                    end
                end
            end
        end
        if (last) begin
            if (!got_byte)
                kind = KIND_EMPTY;
            else if (bad_utf8 || cont_left != 2'd0)
                kind = KIND_INVALID;
            else if (only_cjk)
                kind = KIND_TEXT;
            else if (only_code)
                kind = KIND_CODE;
            else
                kind = KIND_INVALID;
            kinds_due.insert(kinds_due.size(), kind);
            clear_query();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_query();
            kinds_due.delete();
            o_errors = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (kinds_due.size() == 0) begin
                    $error("query_kind: expected no word, actual %0d", i_m_tdata[1:0]);
                    o_errors++;
                end else begin
                    want_kind = kinds_due.pop_front();
                    if (i_m_tdata[1:0] !== want_kind) begin
                        $error("query_kind: expected %0d, actual %0d", want_kind, i_m_tdata[1:0]);
                        o_errors++;
                    end
                    if (i_m_tdata[7:2] !== 6'd0) begin
                        $error("tdata padding: expected 0, actual %0h", i_m_tdata[7:2]);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_word(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        o_outstanding = kinds_due.size();
    end

endmodule

/* test/utf8_query_classifier_test.sv */
// utf8_query_classifier_test: drives directed and random queries into the classifier
// with random idling on both sides, then reports the verdict of the checker
// depends on utf8_query_classifier, utf8_query_classifier_checker and utf8qc_pkg

module utf8_query_classifier_test;

    typedef enum int {Q_TEXT, Q_CODE, Q_MIXED, Q_NOISE, Q_BROKEN} t_query_flavor;
    typedef enum int {F_BAD_LEAD, F_STRAY_CONT, F_OVERLONG, F_SURROGATE, F_TOO_BIG,
                      F_CUT_SHORT} t_utf8_fault;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // data_byte[7:0]
    logic       s_axis_tuser;   // has_byte
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // query_kind[1:0], zeros above

    int         error_count;
    int         outstanding;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         words_sent;
    bit         rx_hold_req;
    logic [7:0] qbytes [$];

    utf8_query_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    utf8_query_classifier_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_errors      (error_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side, with one long hold-off when requested
    initial begin : rx_side
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !hold_done) begin
                repeat (300) begin
                    m_axis_tready <= 1'b0;
                    @(negedge i_clk);
                end
                hold_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] data, input logic has, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        qbytes.insert(qbytes.size(), b);
    endfunction

    function automatic void add_enc(input logic [20:0] cp, input int len);
        case (len)
            1: put_byte(cp[7:0]);
            2: begin
                put_byte({3'b110, cp[10:6]});
                put_byte({2'b10, cp[5:0]});
            end
            3: begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
            default: begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({2'b10, cp[17:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_cp(input logic [20:0] cp);
        add_enc(cp, (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4);
    endfunction

    function automatic logic [20:0] cjk_cp();
        case ($urandom_range(2))
            0:       return 21'($urandom_range(21'h3400, 21'h4dbf));
            1:       return 21'($urandom_range(21'h4e00, 21'h9fff));
            default: return 21'($urandom_range(21'h20000, 21'h3134f));
        endcase
    endfunction

    function automatic logic [20:0] code_cp();
        case ($urandom_range(27))
            26:      return 21'h3a;
            27:      return 21'h27;
            default: return 21'h61 + 21'($urandom_range(25));
        endcase
    endfunction

    function automatic logic [20:0] any_cp();
        logic [20:0] cp;
        case ($urandom_range(5))
            0: cp = 21'($urandom_range(21'h7f));
            1: cp = 21'($urandom_range(21'h80, 21'h7ff));
            2: begin
                cp = 21'($urandom_range(21'h800, 21'hffff));
                if (cp >= 21'hd800 && cp <= 21'hdfff)
                    cp = cp ^ 21'h4000;
            end
            3: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
            4: cp = cjk_cp();
            default: cp = code_cp();
        endcase
        return cp;
    endfunction

    // one query: well-formed content, or noise, or one fault at a random place
    task automatic send_query();
        t_query_flavor flavor;
        t_utf8_fault   fault;
        int            pick;
        int            n_cps;
        int            fault_at;
        int            len;
        logic          last_on_byte;
        pick = $urandom_range(99);
        if (pick < 25)
            flavor = Q_TEXT;
        else if (pick < 50)
            flavor = Q_CODE;
        else if (pick < 65)
            flavor = Q_MIXED;
        else if (pick < 75)
            flavor = Q_NOISE;
        else
            flavor = Q_BROKEN;
        n_cps    = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6);
        fault_at = $urandom_range(n_cps);
        qbytes.delete();
        for (int i = 0; i <= n_cps; i++) begin
            if (flavor == Q_BROKEN && i == fault_at) begin
                fault = t_utf8_fault'($urandom_range(5));
                len   = $urandom_range(2, 4);
                case (fault)
                    F_BAD_LEAD:   put_byte(8'($urandom_range(8'hf8, 8'hff)));
                    F_STRAY_CONT: put_byte(8'($urandom_range(8'h80, 8'hbf)));
                    F_OVERLONG:   add_enc(21'($urandom_range((len == 2) ? 21'h7f :
                                                             (len == 3) ? 21'h7ff : 21'hffff)),
                                          len);
                    F_SURROGATE:  add_enc(21'($urandom_range(21'hd800, 21'hdfff)), 3);
                    F_TOO_BIG:    add_enc(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
                    default: begin
                        add_enc((len == 2) ? 21'($urandom_range(21'h80, 21'h7ff)) :
                                (len == 3) ? 21'($urandom_range(21'h800, 21'hffff)) :
                                             21'($urandom_range(21'h10000, 21'h10ffff)), len);
                        repeat ($urandom_range(1, len - 1))
                            void'(qbytes.pop_back());
                    end
                endcase
            end
            if (i < n_cps) begin
                case (flavor)
                    Q_TEXT:  add_cp(cjk_cp());
                    Q_CODE:  add_cp(code_cp());
                    Q_NOISE: put_byte(8'($urandom_range(255)));
                    default: add_cp(any_cp());
                endcase
            end
        end
        last_on_byte = (qbytes.size() > 0) && $urandom_range(1);
        foreach (qbytes[i]) begin
            if ($urandom_range(11) == 0)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(qbytes[i], 1'b1, last_on_byte && (i == qbytes.size() - 1));
        end
        if (!last_on_byte)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        words_sent    = 0;
        rx_hold_req   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty query
        send_word(8'h00, 1'b0, 1'b1);
        // code chars
        send_word(8'h7a, 1'b1, 1'b0);
        send_word(8'h3a, 1'b1, 1'b0);
        send_word(8'h27, 1'b1, 1'b1);
        // cjk range edges, last one in the four-byte range
        send_word(8'he3, 1'b1, 1'b0);
        send_word(8'h90, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'he9, 1'b1, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0);
        send_word(8'hbf, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'hf0, 1'b1, 1'b0);
        send_word(8'hb1, 1'b1, 1'b0);
        send_word(8'h8d, 1'b1, 1'b0);
        send_word(8'h8f, 1'b1, 1'b1);
        // bad lead, rest of the query ignored
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        // sequence cut off by the end of the query
        send_word(8'he4, 1'b1, 1'b1);
        // overlong two-byte form
        send_word(8'hc0, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        // surrogate
        send_word(8'hed, 1'b1, 1'b0);
        send_word(8'ha0, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        // idle word, then a value above the unicode range
        send_word(8'haa, 1'b0, 1'b0);
        send_word(8'hf4, 1'b1, 1'b0);
        send_word(8'h90, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        drain();

        words_sent    = 0;
        send_idle_pct = 28;
        recv_idle_pct = 75;
        rx_hold_req   = 1'b1;
        while (words_sent < 320)
            send_query();
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 28;
        while (words_sent < 640)
            send_query();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (words_sent < 950)
            send_query();
        drain();

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
